// ===== design/lafu_pkg.sv =====
`default_nettype none

package lafu_pkg;

  localparam int WINDOW_DEPTH_DEF = 4;
  localparam int POS_W = 31;
  localparam int WORD_W = 32;
  localparam int CFG_INDEX_W = 1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIST_LIMIT = 1'b0,
    REG_END_MARKER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic shift_zero;
    logic shift_one;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/lafu_cell.sv =====
`default_nettype none

module lafu_cell
  import lafu_pkg::*;
(
  input  wire        clk,
  input  cell_ctrl_t ctrl,
  input  pos_t       din_zero,
  input  pos_t       din_one,
  output pos_t       dout_zero,
  output pos_t       dout_one
);

  pos_t pos_zero_r;
  pos_t pos_one_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_zero) begin
      pos_zero_r <= din_zero;
    end
    if (ctrl.shift_one) begin
      pos_one_r <= din_one;
    end
  end

  assign dout_zero = pos_zero_r;
  assign dout_one  = pos_one_r;

endmodule

`default_nettype wire

// ===== design/location_adjacency_filter_unit.sv =====
// A result is registered in the output stage (the skid entry if it stalls). Throughput:
// one request per cycle while in_tready is high; the window shift, span subtract and
// compare all happen in the accepting cycle, and a two-entry output stage keeps in_tready
// high while one result waits. Reset clears both fill counts and the output stage, sets
// dist_limit to zero and end_marker to all ones; window contents are not reset.
`default_nettype none

module location_adjacency_filter_unit
  import lafu_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [WORD_W-1:0]     in_tdata,   // [31:0] location
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [WORD_W-1:0]     out_tdata,  // [31:0] out_word
  output logic                  out_tlast,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [WORD_W-1:0]     cfg_data
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

  pos_t  dist_limit_r;
  word_t end_marker_r;

  logic [FILL_W-1:0] fill_zero_r, fill_zero_nxt;
  logic [FILL_W-1:0] fill_one_r, fill_one_nxt;

  logic  out_valid_r, out_valid_nxt;
  word_t out_data_r, out_data_nxt;
  logic  out_last_r, out_last_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  word_t skid_data_r, skid_data_nxt;
  logic  skid_last_r, skid_last_nxt;

  pos_t win_zero [WINDOW_DEPTH+1];
  pos_t win_one  [WINDOW_DEPTH+1];

  logic       in_accept;
  logic       is_end;
  logic       strand;
  pos_t       pos;
  pos_t       oldest;
  logic       full_sel;
  word_t      span;
  logic       hit;
  logic       res_valid;
  word_t      res_data;
  logic       res_last;
  cell_ctrl_t cell_ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_limit_r <= '0;
      end_marker_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIST_LIMIT: dist_limit_r <= cfg_data[POS_W-1:0];
        REG_END_MARKER: end_marker_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign is_end    = (in_tdata == end_marker_r);
  assign strand    = in_tdata[0];
  assign pos       = in_tdata[WORD_W-1:1];

  assign cell_ctrl.shift_zero = in_accept && !is_end && !strand;
  assign cell_ctrl.shift_one  = in_accept && !is_end && strand;

  assign win_zero[WINDOW_DEPTH] = pos;
  assign win_one[WINDOW_DEPTH]  = pos;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    lafu_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .din_zero  (win_zero[i+1]),
      .din_one   (win_one[i+1]),
      .dout_zero (win_zero[i]),
      .dout_one  (win_one[i])
    );
  end

  assign oldest   = strand ? win_one[0] : win_zero[0];
  assign full_sel = strand ? (fill_one_r == FILL_FULL) : (fill_zero_r == FILL_FULL);
  assign span     = {1'b0, pos} - {1'b0, oldest};
  assign hit      = full_sel && (span[WORD_W-1] || (span < {1'b0, dist_limit_r}));

  assign res_valid = in_accept && (is_end || hit);
  assign res_data  = is_end ? end_marker_r : {1'b0, oldest};
  assign res_last  = is_end;

  always_comb begin
    fill_zero_nxt = fill_zero_r;
    fill_one_nxt  = fill_one_r;
    if (in_accept) begin
      if (is_end) begin
        fill_zero_nxt = '0;
        fill_one_nxt  = '0;
      end else if (strand) begin
        if (fill_one_r != FILL_FULL) begin
          fill_one_nxt = fill_one_r + 1'b1;
        end
      end else begin
        if (fill_zero_r != FILL_FULL) begin
          fill_zero_nxt = fill_zero_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_last_nxt  = skid_last_r;
    if (out_valid_r && !out_tready) begin
      if (res_valid) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
        skid_last_nxt  = res_last;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      out_last_nxt   = skid_last_r;
      skid_valid_nxt = res_valid;
      skid_data_nxt  = res_data;
      skid_last_nxt  = res_last;
    end else begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res_data;
      out_last_nxt  = res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_zero_r  <= '0;
      fill_one_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      fill_zero_r  <= fill_zero_nxt;
      fill_one_r   <= fill_one_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    skid_data_r <= skid_data_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid entry held while output stage is empty.");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_zero_r <= FILL_FULL) && (fill_one_r <= FILL_FULL))
    else $error("Fill count beyond window depth.");

  a_end_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_end) |=> (fill_zero_r == '0) && (fill_one_r == '0))
    else $error("End marker did not clear fill counts.");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_tvalid)
    else $error("Result of an accepted request not presented.");

endmodule

`default_nettype wire
